// ===== design/laser_scan_position_unit_macros.svh =====
// Assertion macros for the laser scan position unit.
// Has no dependencies; included by the files that carry assertions.
`ifndef LASER_SCAN_POSITION_UNIT_MACROS_SVH
`define LASER_SCAN_POSITION_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define LSP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSP_ASSERT(lbl, clk, rst_n, prop, msg)
`define LSP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/lsp_pkg.sv =====
// Shared types and constants of the laser scan position unit.
// Has no dependencies; used by the top level and the testbench.
package lsp_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCAN_MODE    = 3'd0,
    CFG_BLOCK_LENGTH = 3'd1,
    CFG_HATCH_PITCH  = 3'd2,
    CFG_SCAN_SPEED   = 3'd3,
    CFG_AREA_WIDTH   = 3'd4,
    CFG_AREA_DEPTH   = 3'd5,
    CFG_TOP_HEIGHT   = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    MODE_ISLAND = 1'b0,
    MODE_STRIPE = 1'b1
  } scan_mode_e;

  localparam logic [DATA_W-1:0] RST_BLOCK_LENGTH = 32'd65536;
  localparam logic [DATA_W-1:0] RST_HATCH_PITCH  = 32'd6554;
  localparam logic [DATA_W-1:0] RST_SCAN_SPEED   = 32'd65536000;
  localparam logic [DATA_W-1:0] RST_AREA_WIDTH   = 32'd655360;
  localparam logic [DATA_W-1:0] RST_AREA_DEPTH   = 32'd655360;
  localparam logic [DATA_W-1:0] RST_TOP_HEIGHT   = 32'd0;

endpackage

// ===== design/lsp_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing but its parameters; used by the laser scan position unit.
module lsp_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output logic [PW-1:0] side_o
);

  logic [NW-1:0] num_q  [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [PW-1:0] side_q [NW];
  logic          vld_q  [NW];

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic [NW-1:0] num_d;
    logic [DW-1:0] rem_d;
    logic [DW-1:0] den_d;
    logic [PW-1:0] side_d;
    logic          vld_d;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (g == 0) begin : g_first
      assign num_d  = num_i;
      assign rem_d  = '0;
      assign den_d  = den_i;
      assign side_d = side_i;
      assign vld_d  = valid_i;
    end else begin : g_next
      assign num_d  = num_q[g-1];
      assign rem_d  = rem_q[g-1];
      assign den_d  = den_q[g-1];
      assign side_d = side_q[g-1];
      assign vld_d  = vld_q[g-1];
    end

    assign trial = {rem_d, num_d[NW-1]};
    assign ge    = trial >= {1'b0, den_d};
    assign diff  = trial - {1'b0, den_d};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_d;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[g]  <= {num_d[NW-2:0], ge};
      rem_q[g]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      den_q[g]  <= den_d;
      side_q[g] <= side_d;
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = num_q[NW-1];
  assign rem_o   = rem_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

// ===== design/laser_scan_position_unit.sv =====
// Laser spot position of a back-and-forth hatch scan from an elapsed time.
// Depends on lsp_pkg, lsp_div and the assertion macro header.
// The pipeline is an input register, three chained divider levels that each resolve one
// quotient bit per stage, a product register and an output register.
// Throughput is one item per cycle; busy_o stays low and results cannot be stalled.
// Reset clears the valid pipeline and loads the register defaults.
`include "laser_scan_position_unit_macros.svh"
module laser_scan_position_unit
  import lsp_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [DATA_W-1:0]    elapsed_time_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  output logic                 done_o,
  output logic [DATA_W-1:0]    laser_x_o,
  output logic [DATA_W-1:0]    laser_y_o,
  output logic [DATA_W-1:0]    laser_z_o,
  output logic                 bad_setting_o
);

  localparam int TW  = 2 * DATA_W - FRAC_BITS;
  localparam int LAT = 3 * TW + 3;
  localparam int P2W = 1 + 2 * DATA_W;
  localparam int P3W = 1 + 2 * DATA_W + TW;

  scan_mode_e        mode_q;
  logic [DATA_W-1:0] len_q, pitch_q, speed_q, width_q, depth_q, top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_ISLAND;
      len_q   <= RST_BLOCK_LENGTH;
      pitch_q <= RST_HATCH_PITCH;
      speed_q <= RST_SCAN_SPEED;
      width_q <= RST_AREA_WIDTH;
      depth_q <= RST_AREA_DEPTH;
      top_q   <= RST_TOP_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SCAN_MODE:    mode_q  <= scan_mode_e'(cfg_data_i[0]);
        CFG_BLOCK_LENGTH: len_q   <= cfg_data_i;
        CFG_HATCH_PITCH:  pitch_q <= cfg_data_i;
        CFG_SCAN_SPEED:   speed_q <= cfg_data_i;
        CFG_AREA_WIDTH:   width_q <= cfg_data_i;
        CFG_AREA_DEPTH:   depth_q <= cfg_data_i;
        CFG_TOP_HEIGHT:   top_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic                a_valid_q;
  logic                a_bad_q;
  logic [2*DATA_W-1:0] a_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    a_prod_q <= (2*DATA_W)'(elapsed_time_i) * (2*DATA_W)'(speed_q);
    a_bad_q  <= (len_q == '0) || (pitch_q == '0);
  end

  logic              d1_valid, d1_bad;
  logic [TW-1:0]     d1_rep, d1_lines, d1_prow;
  logic [DATA_W-1:0] d1_part;
  logic [DATA_W-1:0] lines_num;

  assign lines_num = (mode_q == MODE_STRIPE) ? depth_q : len_q;

  lsp_div #(.NW(TW), .DW(DATA_W), .PW(1)) u_div_rep (
    .clk_i, .rst_ni,
    .valid_i(a_valid_q), .num_i(a_prod_q[2*DATA_W-1:FRAC_BITS]), .den_i(len_q),
    .side_i(a_bad_q),
    .valid_o(d1_valid), .quo_o(d1_rep), .rem_o(d1_part), .side_o(d1_bad)
  );

  lsp_div #(.NW(TW), .DW(DATA_W), .PW(1)) u_div_lines (
    .clk_i, .rst_ni,
    .valid_i(a_valid_q), .num_i({{(TW-DATA_W){1'b0}}, lines_num}), .den_i(pitch_q),
    .side_i(1'b0),
    .valid_o(), .quo_o(d1_lines), .rem_o(), .side_o()
  );

  lsp_div #(.NW(TW), .DW(DATA_W), .PW(1)) u_div_row (
    .clk_i, .rst_ni,
    .valid_i(a_valid_q), .num_i({{(TW-DATA_W){1'b0}}, width_q}), .den_i(len_q),
    .side_i(1'b0),
    .valid_o(), .quo_o(d1_prow), .rem_o(), .side_o()
  );

  logic b_bad;
  assign b_bad = d1_bad || (d1_lines[DATA_W-1:0] == '0) ||
                 ((mode_q == MODE_ISLAND) && (d1_prow[DATA_W-1:0] == '0));

  logic              d2_valid;
  logic [TW-1:0]     d2_quo;
  logic [DATA_W-1:0] d2_line;
  logic [P2W-1:0]    d2_side;

  lsp_div #(.NW(TW), .DW(DATA_W), .PW(P2W)) u_div_line (
    .clk_i, .rst_ni,
    .valid_i(d1_valid), .num_i(d1_rep), .den_i(d1_lines[DATA_W-1:0]),
    .side_i({b_bad, d1_part, d1_prow[DATA_W-1:0]}),
    .valid_o(d2_valid), .quo_o(d2_quo), .rem_o(d2_line), .side_o(d2_side)
  );

  logic              d3_valid;
  logic [TW-1:0]     d3_row;
  logic [DATA_W-1:0] d3_col;
  logic [P3W-1:0]    d3_side;
  logic              d3_bad;
  logic [DATA_W-1:0] d3_part, d3_line;
  logic [TW-1:0]     d3_stripe;

  lsp_div #(.NW(TW), .DW(DATA_W), .PW(P3W)) u_div_col (
    .clk_i, .rst_ni,
    .valid_i(d2_valid), .num_i(d2_quo), .den_i(d2_side[DATA_W-1:0]),
    .side_i({d2_side[P2W-1:DATA_W], d2_line, d2_quo}),
    .valid_o(d3_valid), .quo_o(d3_row), .rem_o(d3_col), .side_o(d3_side)
  );

  assign {d3_bad, d3_part, d3_line, d3_stripe} = d3_side;

  logic [TW-1:0]       mul_a;
  logic                c_valid_q, c_bad_q, c_big_q, c_lodd_q, c_codd_q, c_inwin_q;
  logic [2*DATA_W-1:0] c_mrow_q, c_mcol_q, c_mline_q;
  logic [DATA_W-1:0]   c_part_q;

  assign mul_a = (mode_q == MODE_STRIPE) ? d3_stripe : d3_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else begin
      c_valid_q <= d3_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    c_bad_q   <= d3_bad;
    c_big_q   <= |mul_a[TW-1:DATA_W];
    c_mrow_q  <= (2*DATA_W)'(mul_a[DATA_W-1:0]) * (2*DATA_W)'(len_q);
    c_mcol_q  <= (2*DATA_W)'(d3_col) * (2*DATA_W)'(len_q);
    c_mline_q <= (2*DATA_W)'(d3_line) * (2*DATA_W)'(pitch_q);
    c_part_q  <= d3_part;
    c_lodd_q  <= d3_line[0];
    c_codd_q  <= d3_col[0];
    c_inwin_q <= (d3_part != '0) && (d3_part < depth_q);
  end

  localparam int SW = 2 * DATA_W + 2;

  logic [DATA_W-1:0] along;
  logic [SW-1:0]     x_isl, y_isl, x_str, y_str, x_sum, y_sum;
  logic              x_big, y_big;
  logic [DATA_W-1:0] x_d, y_d;

  always_comb begin
    along = c_lodd_q ? (len_q - c_part_q) : c_part_q;
    x_isl = SW'(c_mcol_q)
          + (c_codd_q ? SW'(c_mline_q) : SW'(along));
    y_isl = SW'(c_mrow_q)
          + (c_codd_q ? SW'(along) : SW'(c_mline_q));
    x_str = c_lodd_q ? (SW'(c_mrow_q) + SW'(len_q) - SW'(c_part_q))
                     : (SW'(c_mrow_q) + SW'(c_part_q));
    y_str = SW'(c_mline_q) + (c_inwin_q ? SW'(pitch_q) : SW'(0));
    if (mode_q == MODE_STRIPE) begin
      x_sum = x_str;
      y_sum = y_str;
      x_big = c_big_q;
      y_big = 1'b0;
    end else begin
      x_sum = x_isl;
      y_sum = y_isl;
      x_big = 1'b0;
      y_big = c_big_q;
    end
    x_d = (x_big || (x_sum[SW-1:DATA_W] != '0)) ? '1 : x_sum[DATA_W-1:0];
    y_d = (y_big || (y_sum[SW-1:DATA_W] != '0)) ? '1 : y_sum[DATA_W-1:0];
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    laser_x_o     <= c_bad_q ? '0 : x_d;
    laser_y_o     <= c_bad_q ? '0 : y_d;
    laser_z_o     <= c_bad_q ? '0 : top_q;
    bad_setting_o <= c_bad_q;
  end

  assign done_o = done_q;

  logic take, take_nolen, bad_out, good_out, zero_out;

  assign take       = start_i && !busy_o;
  assign take_nolen = take && (len_q == '0);
  assign bad_out    = done_o && bad_setting_o;
  assign good_out   = done_o && !bad_setting_o;
  assign zero_out   = (laser_x_o == '0) && (laser_y_o == '0) && (laser_z_o == '0);

  `LSP_ASSERT(a_latency, clk_i, rst_ni, take |-> ##LAT done_o, "result missing")
  `LSP_ASSERT(a_bad_zero, clk_i, rst_ni, bad_out |-> zero_out, "coordinates not zero")
  `LSP_ASSERT(a_zero_len, clk_i, rst_ni, take_nolen |-> ##LAT bad_setting_o, "zero length missed")
  `LSP_ASSERT(a_z_copy, clk_i, rst_ni, good_out |-> laser_z_o == top_q, "z is not top height")

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the laser scan position unit.
// Drives elapsed times and register settings, predicts each spot position and checks it.
// Depends on lsp_pkg and the laser_scan_position_unit top level.
`timescale 1ns / 1ps
module tb_top;
  import lsp_pkg::*;

  localparam int FRAC = 16;
  localparam int LIMIT = 400000;
  localparam int SETTLE = 3 * (64 - FRAC) + 20;
  localparam logic [63:0] SAT64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        bad;
  } spot_t;

  typedef struct {
    scan_mode_e  mode;
    logic [31:0] len;
    logic [31:0] pitch;
    logic [31:0] speed;
    logic [31:0] width;
    logic [31:0] depth;
    logic [31:0] height;
  } setup_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [DATA_W-1:0] elapsed_time_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0] cfg_data_i = '0;
  logic done_o;
  logic [DATA_W-1:0] laser_x_o, laser_y_o, laser_z_o;
  logic bad_setting_o;

  laser_scan_position_unit dut (.*);

  setup_t      regs;
  logic [31:0] time_queue[$];
  spot_t       spot_queue[$];
  int          errors = 0;
  int          cycles = 0;
  bit          took = 1'b0;

  initial forever #10 clk_i = ~clk_i;

  function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return (p[127:64] != 0) ? SAT64 : p[63:0];
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? SAT64 : s[63:0];
  endfunction

  function automatic logic [31:0] clip32(logic [63:0] v);
    return (v[63:32] != 0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic spot_t scan_spot(setup_t r, logic [31:0] t);
    logic [63:0] len, h, travel, rep, part, lines, per_row, blocks, row, col, line, along;
    logic [63:0] x, y;
    logic bad;
    spot_t s;
    len = {32'd0, r.len};
    h = {32'd0, r.pitch};
    x = 0;
    y = 0;
    bad = 1'b0;
    if (len == 0 || h == 0) begin
      bad = 1'b1;
    end else begin
      travel = ({32'd0, t} * {32'd0, r.speed}) >> FRAC;
      rep = travel / len;
      part = travel - rep * len;
      if (r.mode == MODE_ISLAND) begin
        lines = len / h;
        per_row = {32'd0, r.width} / len;
        if (lines == 0 || per_row == 0) begin
          bad = 1'b1;
        end else begin
          blocks = rep / lines;
          row = blocks / per_row;
          col = blocks % per_row;
          line = rep % lines;
          along = line[0] ? len - part : part;
          x = col * len;
          y = mul_sat(row, len);
          if (!col[0]) begin
            x = add_sat(x, along);
            y = add_sat(y, line * h);
          end else begin
            y = add_sat(y, along);
            x = add_sat(x, line * h);
          end
        end
      end else begin
        lines = {32'd0, r.depth} / h;
        if (lines == 0) begin
          bad = 1'b1;
        end else begin
          row = rep / lines;
          line = rep % lines;
          if (line[0]) x = mul_sat(row + 1, len) - part;
          else x = add_sat(mul_sat(row, len), part);
          y = (part > 0 && part < r.depth) ? line * h + h : line * h;
        end
      end
    end
    if (bad) begin
      s = '{x: 32'd0, y: 32'd0, z: 32'd0, bad: 1'b1};
    end else begin
      s = '{x: clip32(x), y: clip32(y), z: r.height, bad: 1'b0};
    end
    return s;
  endfunction

  // Input side: one transfer per start cycle, with random gaps outside a quiet window.
  always @(negedge clk_i) begin
    if (start_i && !took) begin
      start_i <= 1'b1;
    end else if (rst_ni && time_queue.size() > 0 &&
                 ((cycles > 3000 && cycles < 6000) || $urandom_range(99) >= 15)) begin
      start_i <= 1'b1;
      elapsed_time_i <= time_queue.pop_front();
    end else begin
      start_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    spot_t want;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
    took <= start_i && !busy_o;
    if (rst_ni && done_o) begin
      if (spot_queue.size() == 0) begin
        $error("result with no transfer pending");
        errors++;
      end else begin
        want = spot_queue.pop_front();
        if (laser_x_o !== want.x) begin
          $error("laser_x expected %h got %h", want.x, laser_x_o);
          errors++;
        end
        if (laser_y_o !== want.y) begin
          $error("laser_y expected %h got %h", want.y, laser_y_o);
          errors++;
        end
        if (laser_z_o !== want.z) begin
          $error("laser_z expected %h got %h", want.z, laser_z_o);
          errors++;
        end
        if (bad_setting_o !== want.bad) begin
          $error("bad_setting expected %b got %b", want.bad, bad_setting_o);
          errors++;
        end
      end
    end
    if (rst_ni && start_i && !busy_o) spot_queue.push_back(scan_spot(regs, elapsed_time_i));
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCAN_MODE:    regs.mode <= scan_mode_e'(cfg_data_i[0]);
        CFG_BLOCK_LENGTH: regs.len <= cfg_data_i;
        CFG_HATCH_PITCH:  regs.pitch <= cfg_data_i;
        CFG_SCAN_SPEED:   regs.speed <= cfg_data_i;
        CFG_AREA_WIDTH:   regs.width <= cfg_data_i;
        CFG_AREA_DEPTH:   regs.depth <= cfg_data_i;
        CFG_TOP_HEIGHT:   regs.height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
  endtask

  task automatic load_setup(setup_t s);
    write_reg(CFG_SCAN_MODE, {31'd0, s.mode});
    write_reg(CFG_BLOCK_LENGTH, s.len);
    write_reg(CFG_HATCH_PITCH, s.pitch);
    write_reg(CFG_SCAN_SPEED, s.speed);
    write_reg(CFG_AREA_WIDTH, s.width);
    write_reg(CFG_AREA_DEPTH, s.depth);
    write_reg(CFG_TOP_HEIGHT, s.height);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (time_queue.size() != 0 || start_i || spot_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic setup_t mk(scan_mode_e m, logic [31:0] l, logic [31:0] p,
                                logic [31:0] v, logic [31:0] w, logic [31:0] d,
                                logic [31:0] z);
    setup_t s;
    s = '{mode: m, len: l, pitch: p, speed: v, width: w, depth: d, height: z};
    return s;
  endfunction

  function automatic logic [31:0] any32();
    case ($urandom_range(3))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic setup_t rand_setup();
    setup_t s;
    if ($urandom_range(5) == 0) begin
      s = mk(scan_mode_e'($urandom_range(1)), any32(), any32(), any32(), any32(), any32(),
             $urandom);
    end else begin
      s.mode = scan_mode_e'($urandom_range(1));
      s.pitch = $urandom_range(1, 32'h4_0000);
      s.len = s.pitch * $urandom_range(1, 20) + $urandom_range(0, s.pitch - 1);
      s.width = s.len * $urandom_range(1, 8) + $urandom_range(0, 1000);
      s.depth = s.pitch * $urandom_range(1, 30) + $urandom_range(0, 1000);
      s.speed = ($urandom_range(1) != 0) ? $urandom : $urandom_range(1, 32'h100_0000);
      s.height = $urandom;
    end
    return s;
  endfunction

  localparam logic [31:0] MAXV = 32'hFFFF_FFFF;
  localparam logic [31:0] ONE = 32'h1_0000;

  initial begin
    setup_t fixed[10];
    regs = mk(MODE_ISLAND, RST_BLOCK_LENGTH, RST_HATCH_PITCH, RST_SCAN_SPEED,
              RST_AREA_WIDTH, RST_AREA_DEPTH, RST_TOP_HEIGHT);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Defaults straight after reset.
    time_queue = '{32'd0, 32'd1, MAXV, 32'h8000_0000, ONE, 32'h0000_0040, 32'h0000_0123};
    drain();

    fixed[0] = mk(MODE_STRIPE, ONE, 6554, 65536000, 655360, 655360, 32'h1234_5678);
    fixed[1] = mk(MODE_ISLAND, 0, 6554, ONE, 655360, 655360, 1);
    fixed[2] = mk(MODE_STRIPE, ONE, 0, ONE, 655360, 655360, 1);
    fixed[3] = mk(MODE_ISLAND, 100, 200, ONE, 655360, 655360, 1);
    fixed[4] = mk(MODE_ISLAND, 1000, 10, ONE, 999, 655360, 1);
    fixed[5] = mk(MODE_STRIPE, 1000, 200, ONE, 655360, 199, 1);
    fixed[6] = mk(MODE_ISLAND, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
    fixed[7] = mk(MODE_STRIPE, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
    fixed[8] = mk(MODE_ISLAND, 1, 1, MAXV, 2, MAXV, 0);
    fixed[9] = mk(MODE_STRIPE, 1, 1, MAXV, MAXV, 2, MAXV);
    foreach (fixed[i]) begin
      load_setup(fixed[i]);
      time_queue = '{32'd0, MAXV, 32'd3};
      drain();
    end
    // Stripe y offset at a partial travel just inside and at the depth.
    load_setup(mk(MODE_STRIPE, 100, 10, ONE, 1000, 50, 7));
    time_queue = '{32'd49, 32'd50, 32'd100};
    drain();

    repeat (14) begin
      load_setup(rand_setup());
      repeat (30) begin
        time_queue.push_back(($urandom_range(1) != 0) ? $urandom : $urandom_range(0, 1 << 20));
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== laser_scan_position_unit.f =====
+incdir+design
design/lsp_pkg.sv
design/lsp_div.sv
design/laser_scan_position_unit.sv
test/tb_top.sv
